// ===== rtl/modbus_rtu_response_checker_defines.svh =====
// Assertion macros for the Modbus RTU response checker.
// Expects signals clk and rst_n in the module that uses them.
`ifndef MODBUS_RTU_RESPONSE_CHECKER_DEFINES_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS
`define MRC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mrc assertion failed");
`define MRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mrc assertion failed");
`else
`define MRC_ASSERT_SAME(lbl, ante, cons)
`define MRC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/mrc_pkg.sv =====
// Types, codes and the CRC16 byte update for the Modbus RTU response checker.
// No dependencies.
package mrc_pkg;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic [1:0] request_function;
    logic [6:0] quantity;
  } in_t;

  typedef struct packed {
    logic        is_status;
    logic [15:0] register_value;
    logic [6:0]  register_index;
    logic [2:0]  status;
    logic [7:0]  exception_code;
  } out_t;

  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_BYTE    = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  localparam logic [1:0] FN_READ_HOLD   = 2'd0;
  localparam logic [1:0] FN_WRITE_ONE   = 2'd1;
  localparam logic [1:0] FN_WRITE_MULTI = 2'd2;
  localparam logic [1:0] FN_ALIAS_MULTI = 2'd3;

  localparam logic [7:0] FC_READ_HOLD   = 8'h03;
  localparam logic [7:0] FC_WRITE_ONE   = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTI = 8'h10;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TIMEOUT   = 3'd1;
  localparam logic [2:0] ST_CRC       = 3'd2;
  localparam logic [2:0] ST_FRAME     = 3'd3;
  localparam logic [2:0] ST_EXCEPTION = 3'd4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] WRITE_RESP_LEN = 8'd8;
  localparam logic [7:0] READ_HDR_LEN   = 8'd5;
  localparam logic [7:0] DATA_START     = 8'd3;

  // reflected CRC16, one byte, eight shift steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/mrc_in_reg.sv =====
// Input register stage of the Modbus RTU response checker.
// Uses mrc_pkg::in_t.
module mrc_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mrc_pkg::in_t  in_data,
  output logic          item_valid,
  input  logic          item_ready,
  output mrc_pkg::in_t  item
);

  logic         valid_r;
  mrc_pkg::in_t data_r;

  assign in_stall   = valid_r && !item_ready;
  assign item_valid = valid_r;
  assign item       = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      data_r <= in_data;
    end
  end

endmodule

// ===== rtl/mrc_core.sv =====
// Frame state, CRC and status decision, with the result register.
// Uses mrc_pkg and the assertion macros header.
`include "modbus_rtu_response_checker_defines.svh"

module mrc_core #(
  parameter int MAX_READ_WORDS = 125
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          item_valid,
  output logic          item_ready,
  input  mrc_pkg::in_t  item,
  input  logic [7:0]    unit_id,
  output logic          out_valid,
  input  logic          out_stall,
  output mrc_pkg::out_t out_data
);

  localparam logic [6:0] MaxQ = 7'(MAX_READ_WORDS);

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  bytes_seen_r, bytes_seen_nxt;
  logic [7:0]  exp_len_r, exp_len_nxt;
  logic [1:0]  act_fn_r, act_fn_nxt;
  logic [6:0]  act_q_r, act_q_nxt;
  logic        addr_ok_r, addr_ok_nxt;
  logic [7:0]  fn_byte_r, fn_byte_nxt;
  logic [7:0]  third_r, third_nxt;
  logic [7:0]  pend_hi_r, pend_hi_nxt;
  logic        receiving_r, receiving_nxt;

  logic          out_valid_r;
  mrc_pkg::out_t out_data_r;

  logic          take;
  logic          res_vld;
  mrc_pkg::out_t res;
  logic [6:0]    q_clamp;
  logic [1:0]    fn_sel;
  logic [7:0]    pos;
  logic [7:0]    word_off;
  logic [8:0]    data_end;
  logic [2:0]    st;
  logic [7:0]    want_fc;

  assign item_ready = !out_valid_r || !out_stall;
  assign take       = item_valid && item_ready;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_comb begin
    crc_nxt        = crc_r;
    bytes_seen_nxt = bytes_seen_r;
    exp_len_nxt    = exp_len_r;
    act_fn_nxt     = act_fn_r;
    act_q_nxt      = act_q_r;
    addr_ok_nxt    = addr_ok_r;
    fn_byte_nxt    = fn_byte_r;
    third_nxt      = third_r;
    pend_hi_nxt    = pend_hi_r;
    receiving_nxt  = receiving_r;
    res_vld        = 1'b0;
    res            = '0;
    pos            = bytes_seen_r;
    word_off       = bytes_seen_r - 8'd4;
    data_end       = {1'b0, mrc_pkg::DATA_START} + {1'b0, act_q_r, 1'b0};
    want_fc        = (act_fn_r == mrc_pkg::FN_WRITE_ONE) ? mrc_pkg::FC_WRITE_ONE
                                                          : mrc_pkg::FC_WRITE_MULTI;
    st             = mrc_pkg::ST_OK;

    q_clamp = item.quantity;
    if (q_clamp == 7'd0) begin
      q_clamp = 7'd1;
    end else if (q_clamp > MaxQ) begin
      q_clamp = MaxQ;
    end
    fn_sel = (item.request_function == mrc_pkg::FN_ALIAS_MULTI) ? mrc_pkg::FN_WRITE_MULTI
                                                                 : item.request_function;

    case (item.kind)
      mrc_pkg::KIND_START: begin
        act_fn_nxt     = fn_sel;
        act_q_nxt      = q_clamp;
        exp_len_nxt    = (fn_sel == mrc_pkg::FN_READ_HOLD)
                         ? mrc_pkg::READ_HDR_LEN + {q_clamp, 1'b0}
                         : mrc_pkg::WRITE_RESP_LEN;
        crc_nxt        = mrc_pkg::CRC_INIT;
        bytes_seen_nxt = 8'd0;
        addr_ok_nxt    = 1'b0;
        fn_byte_nxt    = 8'd0;
        third_nxt      = 8'd0;
        pend_hi_nxt    = 8'd0;
        receiving_nxt  = 1'b1;
      end
      mrc_pkg::KIND_TIMEOUT: begin
        if (receiving_r) begin
          receiving_nxt = 1'b0;
          res_vld       = 1'b1;
          res.is_status = 1'b1;
          res.status    = mrc_pkg::ST_TIMEOUT;
        end
      end
      mrc_pkg::KIND_BYTE: begin
        if (receiving_r) begin
          crc_nxt        = mrc_pkg::crc16_byte(crc_r, item.rx_byte);
          bytes_seen_nxt = pos + 8'd1;
          if (pos == 8'd0) begin
            addr_ok_nxt = (item.rx_byte == unit_id);
          end else if (pos == 8'd1) begin
            fn_byte_nxt = item.rx_byte;
          end else if (pos == 8'd2) begin
            third_nxt = item.rx_byte;
          end

          if ({1'b0, pos} + 9'd1 >= {1'b0, exp_len_r}) begin
            // last byte: decide the frame status on the updated fields
            if (crc_nxt != 16'h0000) begin
              st = mrc_pkg::ST_CRC;
            end else if (!addr_ok_nxt) begin
              st = mrc_pkg::ST_FRAME;
            end else if (fn_byte_nxt[7]) begin
              st = mrc_pkg::ST_EXCEPTION;
            end else if (act_fn_r == mrc_pkg::FN_READ_HOLD) begin
              if (fn_byte_nxt != mrc_pkg::FC_READ_HOLD || third_nxt != {act_q_r, 1'b0}) begin
                st = mrc_pkg::ST_FRAME;
              end
            end else if (fn_byte_nxt != want_fc) begin
              st = mrc_pkg::ST_FRAME;
            end
            receiving_nxt      = 1'b0;
            res_vld            = 1'b1;
            res.is_status      = 1'b1;
            res.status         = st;
            res.exception_code = (st == mrc_pkg::ST_EXCEPTION) ? third_nxt : 8'd0;
          end else if (act_fn_r == mrc_pkg::FN_READ_HOLD && pos >= mrc_pkg::DATA_START &&
                       {1'b0, pos} < data_end) begin
            // odd positions carry the high byte, even ones complete a word
            if (pos[0]) begin
              pend_hi_nxt = item.rx_byte;
            end else begin
              res_vld            = 1'b1;
              res.register_value = {pend_hi_r, item.rx_byte};
              res.register_index = word_off[7:1];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r        <= mrc_pkg::CRC_INIT;
      bytes_seen_r <= 8'd0;
      exp_len_r    <= 8'd0;
      act_fn_r     <= 2'd0;
      act_q_r      <= 7'd0;
      addr_ok_r    <= 1'b0;
      fn_byte_r    <= 8'd0;
      third_r      <= 8'd0;
      pend_hi_r    <= 8'd0;
      receiving_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        crc_r        <= crc_nxt;
        bytes_seen_r <= bytes_seen_nxt;
        exp_len_r    <= exp_len_nxt;
        act_fn_r     <= act_fn_nxt;
        act_q_r      <= act_q_nxt;
        addr_ok_r    <= addr_ok_nxt;
        fn_byte_r    <= fn_byte_nxt;
        third_r      <= third_nxt;
        pend_hi_r    <= pend_hi_nxt;
        receiving_r  <= receiving_nxt;
      end
      if (item_ready) begin
        out_valid_r <= take && res_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready) begin
      out_data_r <= res;
    end
  end

  `MRC_ASSERT_NEXT(a_status_closes_frame, take && res_vld && res.is_status, !receiving_r)
  `MRC_ASSERT_SAME(a_pos_below_len, receiving_r, bytes_seen_r < exp_len_r)
  `MRC_ASSERT_SAME(a_word_index_in_range, out_valid_r && !out_data_r.is_status, out_data_r.register_index < act_q_r)

endmodule

// ===== rtl/modbus_rtu_response_checker.sv =====
// Modbus RTU response checker. A result word passes the input register, then the result
// register, before it shows on out_valid; while out_stall is low a new byte is accepted
// as earlier ones move on. The CRC byte update is fully unrolled.
// Synchronous active-low reset: idle, CRC at all ones, unit_id back to 1.
// Uses mrc_pkg, mrc_in_reg and mrc_core.
module modbus_rtu_response_checker #(
  parameter int MAX_READ_WORDS = 125
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mrc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mrc_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_data
);

  logic [7:0]   unit_id_r;
  logic         item_valid;
  logic         item_ready;
  mrc_pkg::in_t item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_id_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unit_id_r <= cfg_data;
    end
  end

  mrc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  mrc_core #(
    .MAX_READ_WORDS (MAX_READ_WORDS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .unit_id    (unit_id_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
